// File: src/triangle_area_from_sides_unit_defines.svh
// Assertion macros used by the checker file.
`ifndef TRIANGLE_AREA_FROM_SIDES_UNIT_DEFINES_SVH
`define TRIANGLE_AREA_FROM_SIDES_UNIT_DEFINES_SVH

// Same-cycle implication, checked at every rising clock edge.
`define TAFS_ASSERT_IMPL(lbl, clk, dis, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked at every rising clock edge.
`define TAFS_ASSERT_NEXT(lbl, clk, dis, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/tafs_pkg.sv
package tafs_pkg;

    // Width of the area result, fixed by the interface.
    localparam int AREA_W = 31;

    typedef logic [AREA_W-1:0] area_t;

endpackage

// File: src/tafs_front.sv
// Triangle check and the four-factor product, three register stages.
module tafs_front #(
    parameter int SIDE_BITS = 12,
    parameter int DW        = 50
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [SIDE_BITS-1:0] side_a,
    input  logic [SIDE_BITS-1:0] side_b,
    input  logic [SIDE_BITS-1:0] side_c,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 out_ok,
    output logic [DW-1:0]        out_d
);

    localparam int SW  = SIDE_BITS + 2;     // a+b+c
    localparam int FW  = SIDE_BITS + 1;     // pairwise sums and differences
    localparam int PW1 = SW + FW;
    localparam int PW2 = 2 * FW;
    localparam int PW3 = PW1 + PW2;

    logic           v1_reg, v2_reg, v3_reg;
    logic           rdy1, rdy2, rdy3;

    logic           ok1_reg, ok2_reg, ok3_reg;
    logic [SW-1:0]  sum_reg;
    logic [FW-1:0]  f1_reg, f2_reg, f3_reg;
    logic [PW1-1:0] p1_reg;
    logic [PW2-1:0] p2_reg;
    logic [DW-1:0]  d_reg;

    logic [FW-1:0]  a_w, b_w, c_w, ab, ac, bc;
    logic           ok_next;
    logic [SW-1:0]  sum_next;
    logic [FW-1:0]  f1_next, f2_next, f3_next;
    logic [PW1-1:0] p1_next;
    logic [PW2-1:0] p2_next;
    logic [PW3-1:0] prod;
    logic [DW-1:0]  d_next;

    // each stage loads when empty or when its successor drains
    assign rdy3     = !v3_reg || out_ready;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    assign a_w = FW'(side_a);
    assign b_w = FW'(side_b);
    assign c_w = FW'(side_c);
    assign ab  = a_w + b_w;
    assign ac  = a_w + c_w;
    assign bc  = b_w + c_w;

    assign ok_next  = (a_w < bc) && (b_w < ac) && (c_w < ab);
    assign sum_next = SW'(side_a) + SW'(side_b) + SW'(side_c);
    // zero the factors of a non-triangle so the product, and the root, is zero
    assign f1_next  = ok_next ? (bc - a_w) : '0;
    assign f2_next  = ok_next ? (ac - b_w) : '0;
    assign f3_next  = ok_next ? (ab - c_w) : '0;

    assign p1_next = PW1'(sum_reg) * PW1'(f1_reg);
    assign p2_next = PW2'(f2_reg) * PW2'(f3_reg);

    // 16 * area^2 stays below 2^(4*SIDE_BITS+2)
    assign prod   = PW3'(p1_reg) * PW3'(p2_reg);
    assign d_next = prod[DW-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (rdy1) begin
                v1_reg <= in_valid;
            end
            if (rdy2) begin
                v2_reg <= v1_reg;
            end
            if (rdy3) begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && rdy1) begin
            ok1_reg <= ok_next;
            sum_reg <= sum_next;
            f1_reg  <= f1_next;
            f2_reg  <= f2_next;
            f3_reg  <= f3_next;
        end
        if (v1_reg && rdy2) begin
            ok2_reg <= ok1_reg;
            p1_reg  <= p1_next;
            p2_reg  <= p2_next;
        end
        if (v2_reg && rdy3) begin
            ok3_reg <= ok2_reg;
            d_reg   <= d_next;
        end
    end

    assign out_valid = v3_reg;
    assign out_ok    = ok3_reg;
    assign out_d     = d_reg;

endmodule

// File: src/tafs_root_step.sv
// One bit of a restoring square root, registered.
module tafs_root_step #(
    parameter int RW = 31
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic            in_ok,
    input  logic [2*RW-1:0] in_rad,
    input  logic [RW+1:0]   in_rem,
    input  logic [RW-1:0]   in_root,
    output logic            out_valid,
    input  logic            out_ready,
    output logic            out_ok,
    output logic [2*RW-1:0] out_rad,
    output logic [RW+1:0]   out_rem,
    output logic [RW-1:0]   out_root
);

    logic            valid_reg;
    logic            ok_reg;
    logic [2*RW-1:0] rad_reg;
    logic [RW+1:0]   rem_reg;
    logic [RW-1:0]   root_reg;

    logic [RW+1:0]   cur, trial;
    logic            fits;
    logic [RW+1:0]   rem_next;
    logic [RW-1:0]   root_next;
    logic [2*RW-1:0] rad_next;

    assign in_ready = !valid_reg || out_ready;

    // bring down the next two radicand bits and try root*4+1
    assign cur       = {in_rem[RW-1:0], in_rad[2*RW-1 -: 2]};
    assign trial     = {in_root, 2'b01};
    assign fits      = cur >= trial;
    assign rem_next  = fits ? (cur - trial) : cur;
    assign root_next = {in_root[RW-2:0], fits};
    assign rad_next  = in_rad << 2;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            ok_reg   <= in_ok;
            rad_reg  <= rad_next;
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_ok    = ok_reg;
    assign out_rad   = rad_reg;
    assign out_rem   = rem_reg;
    assign out_root  = root_reg;

endmodule

// File: src/triangle_area_from_sides_unit.sv
// Channel   Direction  Ports                                   Transfer when
// s_        in         s_side_a, s_side_b, s_side_c            s_valid && s_ready
// m_        out        m_is_triangle, m_area_fixed             m_valid && m_ready
//
// The pipeline has three stages for the triangle check and the two rounds
// of multiplication, then one stage for each root bit. One transfer a
// cycle is sustained in both directions while m_ready stays high. Reset
// clears the valid bits only. A stalled stage holds its contents; empty
// stages before it keep filling, so a waiting result only stops new items
// from entering once every stage holds one.
module triangle_area_from_sides_unit #(
    parameter int SIDE_BITS      = 12,
    parameter int AREA_FRAC_BITS = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [SIDE_BITS-1:0] s_side_a,
    input  logic [SIDE_BITS-1:0] s_side_b,
    input  logic [SIDE_BITS-1:0] s_side_c,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_is_triangle,
    output tafs_pkg::area_t      m_area_fixed
);

    import tafs_pkg::*;

    // D = 16*area^2 = (a+b+c)(b+c-a)(a+c-b)(a+b-c), below 2^(4*SIDE_BITS+2).
    // area * 2^F = floor(sqrt(D * 2^(2F-4))); the scale is a plain shift.
    localparam int DW   = 4 * SIDE_BITS + 2;
    localparam int SHL  = (2 * AREA_FRAC_BITS >= 4) ? 2 * AREA_FRAC_BITS - 4 : 0;
    localparam int SHR  = (2 * AREA_FRAC_BITS >= 4) ? 0 : 4 - 2 * AREA_FRAC_BITS;
    localparam int SCW  = DW + SHL;
    localparam int RW   = (SCW + 1) / 2;    // root bits, one pipeline stage each
    localparam int RADW = 2 * RW;

    logic            f_valid, f_ready, f_ok;
    logic [DW-1:0]   f_d;
    logic [RADW-1:0] rad0;

    // links between root stages; index k feeds stage k
    logic            lk_valid [0:RW];
    logic            lk_ready [0:RW];
    logic            lk_ok    [0:RW];
    logic [RADW-1:0] lk_rad   [0:RW];
    logic [RW+1:0]   lk_rem   [0:RW];
    logic [RW-1:0]   lk_root  [0:RW];

    // Front end: inequality test, factors, product. Non-triangles leave
    // with D forced to zero so the root stages need no special case.
    tafs_front #(
        .SIDE_BITS (SIDE_BITS),
        .DW        (DW)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .side_a    (s_side_a),
        .side_b    (s_side_b),
        .side_c    (s_side_c),
        .out_valid (f_valid),
        .out_ready (f_ready),
        .out_ok    (f_ok),
        .out_d     (f_d)
    );

    // Scale D to the output's fraction bits; shifting right first gives
    // the same floor when fewer than two fraction bits are asked for.
    assign rad0 = (RADW'(f_d) << SHL) >> SHR;

    assign lk_valid[0] = f_valid;
    assign f_ready     = lk_ready[0];
    assign lk_ok[0]    = f_ok;
    assign lk_rad[0]   = rad0;
    assign lk_rem[0]   = '0;
    assign lk_root[0]  = '0;

    // One restoring step per stage, most significant root bit first.
    for (genvar k = 0; k < RW; k++) begin : g_root
        tafs_root_step #(
            .RW (RW)
        ) u_step (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (lk_valid[k]),
            .in_ready  (lk_ready[k]),
            .in_ok     (lk_ok[k]),
            .in_rad    (lk_rad[k]),
            .in_rem    (lk_rem[k]),
            .in_root   (lk_root[k]),
            .out_valid (lk_valid[k+1]),
            .out_ready (lk_ready[k+1]),
            .out_ok    (lk_ok[k+1]),
            .out_rad   (lk_rad[k+1]),
            .out_rem   (lk_rem[k+1]),
            .out_root  (lk_root[k+1])
        );
    end

    // The last root stage doubles as the output register.
    assign m_valid        = lk_valid[RW];
    assign lk_ready[RW]   = m_ready;
    assign m_is_triangle  = lk_ok[RW];
    assign m_area_fixed   = AREA_W'(lk_root[RW]);

endmodule

// File: src/tafs_checker.sv
`include "triangle_area_from_sides_unit_defines.svh"

module tafs_checker (
    input logic            aclk,
    input logic            aresetn,
    input logic            s_valid,
    input logic            s_ready,
    input logic            m_valid,
    input logic            m_ready,
    input logic            m_is_triangle,
    input tafs_pkg::area_t m_area_fixed
);

    // hold a refused result
    `TAFS_ASSERT_NEXT(a_out_hold, aclk, !aresetn, m_valid && !m_ready, m_valid && $stable(m_is_triangle) && $stable(m_area_fixed), "result changed while stalled")

    // a rejected triangle carries zero area
    `TAFS_ASSERT_IMPL(a_bad_zero, aclk, !aresetn, m_valid && !m_is_triangle, m_area_fixed == '0, "non-triangle with non-zero area")

    // reset empties the pipeline
    `TAFS_ASSERT_NEXT(a_reset_empty, aclk, 1'b0, !aresetn, !m_valid, "result valid after reset")

    // an empty output stage lets the whole pipeline advance
    `TAFS_ASSERT_IMPL(a_ready_free, aclk, !aresetn, !m_valid, s_ready, "input refused with output empty")

endmodule

bind triangle_area_from_sides_unit tafs_checker u_tafs_checker (.*);
